// ----- rtl/limit_order_book_macros.svh -----
// assertion macros for the limit order book
`ifndef LIMIT_ORDER_BOOK_MACROS_SVH
`define LIMIT_ORDER_BOOK_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising clock outside reset
`define LOB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define LOB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LOB_ASSERT_IMP(lbl, ante, cons, msg)
`define LOB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/lob_pkg.sv -----
// shared types, constants and helpers of the limit order book
package lob_pkg;

   localparam int ORDER_SLOTS = 4096;
   localparam int PRICE_TICKS = 1024;

   localparam int SLOT_W    = $clog2(ORDER_SLOTS);
   localparam int LINK_W    = $clog2(ORDER_SLOTS + 1);
   localparam int PRICE_W   = $clog2(PRICE_TICKS);
   localparam int LVL_DEPTH = 2 * PRICE_TICKS;
   localparam int LVL_W     = $clog2(LVL_DEPTH);
   localparam int CLR_LEN   = (ORDER_SLOTS > LVL_DEPTH) ? ORDER_SLOTS : LVL_DEPTH;
   localparam int CLR_W     = $clog2(CLR_LEN);
   localparam int TOTAL_W   = 48;

   localparam logic [LINK_W-1:0]  LINK_NULL = LINK_W'(ORDER_SLOTS);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [1:0] FN_ADD    = 2'd0;
   localparam logic [1:0] FN_CANCEL = 2'd1;
   localparam logic [1:0] FN_TRADE  = 2'd2;
   localparam logic [1:0] FN_CHANGE = 2'd3;

   localparam logic [2:0] ST_NONE      = 3'd0;
   localparam logic [2:0] ST_NEW_BID   = 3'd1;
   localparam logic [2:0] ST_NEW_OFFER = 3'd2;
   localparam logic [2:0] ST_UNKNOWN   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_BAD_QTY   = 3'd5;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] ord_id;
      logic        side;
      logic [9:0]  price;
      logic [31:0] quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               bid_present;
      logic [9:0]         best_bid_price;
      logic [TOTAL_W-1:0] best_bid_total;
      logic [31:0]        bid_head_id;
      logic [31:0]        bid_head_qty;
      logic               offer_present;
      logic [9:0]         best_offer_price;
      logic [TOTAL_W-1:0] best_offer_total;
      logic [31:0]        offer_head_id;
      logic [31:0]        offer_head_qty;
   } rsp_type;

   typedef struct packed {
      logic               used;
      logic [31:0]        ord_id;
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [31:0]        qty;
      logic [LINK_W-1:0]  prev;
      logic [LINK_W-1:0]  next;
   } slot_type;

   typedef struct packed {
      logic               occupied;
      logic [SLOT_W-1:0]  head;
      logic [SLOT_W-1:0]  tail;
      logic [TOTAL_W-1:0] total;
   } level_type;

   // wrap into the tick window; the tick count is a power of two, so this is a mask
   function automatic logic [PRICE_W-1:0] price_mod(input logic [9:0] p);
      return PRICE_W'(32'(p) % PRICE_TICKS);
   endfunction

   function automatic logic [LVL_W-1:0] lvl_idx(input logic side,
                                                 input logic [PRICE_W-1:0] price);
      return side ? LVL_W'(PRICE_TICKS + int'(price)) : LVL_W'(price);
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [31:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + (TOTAL_W + 1)'(b);
      return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
   endfunction

   function automatic logic [TOTAL_W-1:0] floor_sub(input logic [TOTAL_W-1:0] a,
                                                    input logic [31:0] b);
      return (TOTAL_W'(b) > a) ? '0 : a - TOTAL_W'(b);
   endfunction

endpackage

// ----- rtl/lob_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
module lob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/limit_order_book.sv -----
// limit order book top level: sequencer over the order slot and price level rams
//
//  channel | direction | ports                      | moves
//  --------+-----------+----------------------------+------------------------
//  req     | in        | req_valid/req_ready/req_data | one book event
//  rsp     | out       | rsp_valid/rsp_ready/rsp_data | status and top of book
//
// one event at a time; each event first runs a linear scan over the slots
// (lowest free slot for add, lowest matching id otherwise), then fixes each neighbor
// link on add or remove, and walks tick by tick from the best level when it empties;
// a miss scans every slot, a zero add skips the scan, and an oversize trade stops
// after it. after reset a clearing pass zeroes both rams before the first event.
// a new event is taken while the previous response waits on rsp_ready.
`include "limit_order_book_macros.svh"

module limit_order_book (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lob_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lob_pkg::rsp_type rsp_data
);
   import lob_pkg::*;

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_SCAN  = 5'd2;
   localparam logic [4:0] S_LRD   = 5'd3;
   localparam logic [4:0] S_LMOD  = 5'd4;
   localparam logic [4:0] S_TRD   = 5'd5;
   localparam logic [4:0] S_TWR   = 5'd6;
   localparam logic [4:0] S_PRD   = 5'd7;
   localparam logic [4:0] S_PWR   = 5'd8;
   localparam logic [4:0] S_NRD   = 5'd9;
   localparam logic [4:0] S_NWR   = 5'd10;
   localparam logic [4:0] S_BEST  = 5'd11;
   localparam logic [4:0] S_LSCAN = 5'd12;
   localparam logic [4:0] S_STAT  = 5'd13;
   localparam logic [4:0] S_OB1   = 5'd14;
   localparam logic [4:0] S_OB2   = 5'd15;
   localparam logic [4:0] S_OB3   = 5'd16;
   localparam logic [4:0] S_OB4   = 5'd17;
   localparam logic [4:0] S_DONE  = 5'd18;

   // ram ports
   logic               slot_we;
   logic [SLOT_W-1:0]  slot_waddr;
   slot_type           slot_wdata;
   logic [SLOT_W-1:0]  slot_raddr;
   slot_type           slot_q;
   logic               lvl_we;
   logic [LVL_W-1:0]   lvl_waddr;
   level_type          lvl_wdata;
   logic [LVL_W-1:0]   lvl_raddr;
   level_type          lvl_q;

   // registers
   logic [4:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   logic [PRICE_W-1:0] pm_ff, pm_in;
   logic [CLR_W-1:0]   cnt_ff, cnt_in;
   logic [CLR_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]  s_ff, s_in;
   slot_type           sd_ff, sd_in;
   level_type          lv_ff, lv_in;
   logic [LVL_W-1:0]   l_ff, l_in;
   logic               t_side_ff, t_side_in;
   logic [PRICE_W-1:0] t_price_ff, t_price_in;
   logic               touched_ff, touched_in;
   logic               occ_new_ff, occ_new_in;
   logic               bid_valid_ff, bid_valid_in;
   logic [PRICE_W-1:0] best_bid_ff, best_bid_in;
   logic               offer_valid_ff, offer_valid_in;
   logic [PRICE_W-1:0] best_offer_ff, best_offer_in;
   logic               old_bv_ff, old_bv_in;
   logic [PRICE_W-1:0] old_bid_ff, old_bid_in;
   logic               old_ov_ff, old_ov_in;
   logic [PRICE_W-1:0] old_offer_ff, old_offer_in;
   logic [2:0]         status_ff, status_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // decode helpers
   logic               hit;
   logic               is_remove;
   logic               p_ok;
   logic               n_ok;
   logic               lvl_empty;
   logic [31:0]        old_qty;

   lob_ram #(.WIDTH($bits(slot_type)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_q)
   );

   lob_ram #(.WIDTH($bits(level_type)), .DEPTH(LVL_DEPTH)) u_level_ram (
      .clock (clock),
      .we    (lvl_we),
      .waddr (lvl_waddr),
      .wdata (lvl_wdata),
      .raddr (lvl_raddr),
      .rdata (lvl_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign old_qty   = sd_ff.qty;
   assign is_remove = (req_ff.func == FN_CANCEL)
                    || ((req_ff.func == FN_TRADE) && (req_ff.quantity == old_qty))
                    || ((req_ff.func == FN_CHANGE) && (req_ff.quantity == 32'd0));
   assign p_ok      = (sd_ff.prev < LINK_NULL);
   assign n_ok      = (sd_ff.next < LINK_NULL);
   assign lvl_empty = !p_ok && !n_ok;
   assign hit       = chk_vld_ff && ((req_ff.func == FN_ADD) ? !slot_q.used
                      : (slot_q.used && (slot_q.ord_id == req_ff.ord_id)));

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      pm_in          = pm_ff;
      cnt_in         = cnt_ff;
      chk_idx_in     = chk_idx_ff;
      chk_vld_in     = chk_vld_ff;
      s_in           = s_ff;
      sd_in          = sd_ff;
      lv_in          = lv_ff;
      l_in           = l_ff;
      t_side_in      = t_side_ff;
      t_price_in     = t_price_ff;
      touched_in     = touched_ff;
      occ_new_in     = occ_new_ff;
      bid_valid_in   = bid_valid_ff;
      best_bid_in    = best_bid_ff;
      offer_valid_in = offer_valid_ff;
      best_offer_in  = best_offer_ff;
      old_bv_in      = old_bv_ff;
      old_bid_in     = old_bid_ff;
      old_ov_in      = old_ov_ff;
      old_offer_in   = old_offer_ff;
      status_in      = status_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      slot_we    = 1'b0;
      slot_waddr = s_ff;
      slot_wdata = sd_ff;
      slot_raddr = cnt_ff[SLOT_W-1:0];
      lvl_we     = 1'b0;
      lvl_waddr  = l_ff;
      lvl_wdata  = lv_ff;
      lvl_raddr  = l_ff;

      unique case (state_ff)
         S_CLR: begin
            slot_we    = (32'(cnt_ff) < ORDER_SLOTS);
            slot_waddr = cnt_ff[SLOT_W-1:0];
            slot_wdata = '0;
            lvl_we     = (32'(cnt_ff) < LVL_DEPTH);
            lvl_waddr  = cnt_ff[LVL_W-1:0];
            lvl_wdata  = '0;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CLR_W'(CLR_LEN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               pm_in        = price_mod(req_data.price);
               old_bv_in    = bid_valid_ff;
               old_bid_in   = best_bid_ff;
               old_ov_in    = offer_valid_ff;
               old_offer_in = best_offer_ff;
               touched_in   = 1'b0;
               status_in    = ST_NONE;
               cnt_in       = '0;
               chk_vld_in   = 1'b0;
               if ((req_data.func == FN_ADD) && (req_data.quantity == 32'd0)) begin
                  status_in = ST_BAD_QTY;
                  state_in  = S_STAT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read issued here comes back with chk_idx next cycle
            slot_raddr = cnt_ff[SLOT_W-1:0];
            cnt_in     = cnt_ff + 1'b1;
            chk_idx_in = cnt_ff;
            chk_vld_in = 1'b1;
            if (hit) begin
               s_in  = chk_idx_ff[SLOT_W-1:0];
               sd_in = slot_q;
               if (req_ff.func == FN_ADD) begin
                  t_side_in  = req_ff.side;
                  t_price_in = pm_ff;
                  l_in       = lvl_idx(req_ff.side, pm_ff);
                  touched_in = 1'b1;
                  state_in   = S_LRD;
               end else if ((req_ff.func == FN_TRADE) && (req_ff.quantity > slot_q.qty)) begin
                  status_in = ST_BAD_QTY;
                  state_in  = S_STAT;
               end else begin
                  t_side_in  = slot_q.side;
                  t_price_in = slot_q.price;
                  l_in       = lvl_idx(slot_q.side, slot_q.price);
                  touched_in = 1'b1;
                  state_in   = S_LRD;
               end
            end else if (chk_vld_ff && (chk_idx_ff[SLOT_W-1:0] == SLOT_W'(ORDER_SLOTS - 1))) begin
               status_in = (req_ff.func == FN_ADD) ? ST_FULL : ST_UNKNOWN;
               state_in  = S_STAT;
            end
         end
         S_LRD: begin
            lvl_raddr = l_ff;
            state_in  = S_LMOD;
         end
         S_LMOD: begin
            lv_in      = lvl_q;
            slot_we    = 1'b1;
            slot_waddr = s_ff;
            lvl_we     = 1'b1;
            lvl_waddr  = l_ff;
            occ_new_in = 1'b1;
            state_in   = S_BEST;
            if (req_ff.func == FN_ADD) begin
               slot_wdata.used   = 1'b1;
               slot_wdata.ord_id = req_ff.ord_id;
               slot_wdata.side   = req_ff.side;
               slot_wdata.price  = pm_ff;
               slot_wdata.qty    = req_ff.quantity;
               slot_wdata.next   = LINK_NULL;
               if (lvl_q.occupied) begin
                  slot_wdata.prev = LINK_W'(lvl_q.tail);
                  lvl_wdata       = lvl_q;
                  lvl_wdata.tail  = s_ff;
                  lvl_wdata.total = sat_add(lvl_q.total, req_ff.quantity);
                  state_in        = S_TRD;
               end else begin
                  slot_wdata.prev     = LINK_NULL;
                  lvl_wdata.occupied  = 1'b1;
                  lvl_wdata.head      = s_ff;
                  lvl_wdata.tail      = s_ff;
                  lvl_wdata.total     = TOTAL_W'(req_ff.quantity);
               end
            end else if (is_remove) begin
               slot_wdata         = sd_ff;
               slot_wdata.used    = 1'b0;
               lvl_wdata.occupied = !lvl_empty;
               lvl_wdata.head     = p_ok ? lvl_q.head : sd_ff.next[SLOT_W-1:0];
               lvl_wdata.tail     = n_ok ? lvl_q.tail : sd_ff.prev[SLOT_W-1:0];
               lvl_wdata.total    = lvl_empty ? '0 : floor_sub(lvl_q.total, old_qty);
               occ_new_in         = !lvl_empty;
               if (p_ok) begin
                  state_in = S_PRD;
               end else if (n_ok) begin
                  state_in = S_NRD;
               end
            end else if (req_ff.func == FN_TRADE) begin
               slot_wdata      = sd_ff;
               slot_wdata.qty  = old_qty - req_ff.quantity;
               lvl_wdata       = lvl_q;
               lvl_wdata.total = floor_sub(lvl_q.total, req_ff.quantity);
            end else begin
               slot_wdata     = sd_ff;
               slot_wdata.qty = req_ff.quantity;
               lvl_wdata      = lvl_q;
               if (req_ff.quantity < old_qty) begin
                  lvl_wdata.total = floor_sub(lvl_q.total, old_qty - req_ff.quantity);
               end else begin
                  lvl_wdata.total = sat_add(lvl_q.total, req_ff.quantity - old_qty);
               end
            end
         end
         S_TRD: begin
            slot_raddr = lv_ff.tail;
            state_in   = S_TWR;
         end
         S_TWR: begin
            slot_we         = 1'b1;
            slot_waddr      = lv_ff.tail;
            slot_wdata      = slot_q;
            slot_wdata.next = LINK_W'(s_ff);
            state_in        = S_BEST;
         end
         S_PRD: begin
            slot_raddr = sd_ff.prev[SLOT_W-1:0];
            state_in   = S_PWR;
         end
         S_PWR: begin
            slot_we         = 1'b1;
            slot_waddr      = sd_ff.prev[SLOT_W-1:0];
            slot_wdata      = slot_q;
            slot_wdata.next = sd_ff.next;
            state_in        = n_ok ? S_NRD : S_BEST;
         end
         S_NRD: begin
            slot_raddr = sd_ff.next[SLOT_W-1:0];
            state_in   = S_NWR;
         end
         S_NWR: begin
            slot_we         = 1'b1;
            slot_waddr      = sd_ff.next[SLOT_W-1:0];
            slot_wdata      = slot_q;
            slot_wdata.prev = sd_ff.prev;
            state_in        = S_BEST;
         end
         S_BEST: begin
            state_in   = S_STAT;
            chk_vld_in = 1'b0;
            if (!t_side_ff) begin
               if (occ_new_ff) begin
                  if (!bid_valid_ff || (t_price_ff > best_bid_ff)) begin
                     bid_valid_in = 1'b1;
                     best_bid_in  = t_price_ff;
                  end
               end else if (bid_valid_ff && (best_bid_ff == t_price_ff)) begin
                  if (t_price_ff == '0) begin
                     bid_valid_in = 1'b0;
                     best_bid_in  = '0;
                  end else begin
                     cnt_in   = CLR_W'(t_price_ff) - 1'b1;
                     state_in = S_LSCAN;
                  end
               end
            end else begin
               if (occ_new_ff) begin
                  if (!offer_valid_ff || (t_price_ff < best_offer_ff)) begin
                     offer_valid_in = 1'b1;
                     best_offer_in  = t_price_ff;
                  end
               end else if (offer_valid_ff && (best_offer_ff == t_price_ff)) begin
                  if (t_price_ff == PRICE_W'(PRICE_TICKS - 1)) begin
                     offer_valid_in = 1'b0;
                     best_offer_in  = '0;
                  end else begin
                     cnt_in   = CLR_W'(t_price_ff) + 1'b1;
                     state_in = S_LSCAN;
                  end
               end
            end
         end
         S_LSCAN: begin
            // walk away from the emptied best level until an occupied one shows up or the end of the range is reached
            lvl_raddr  = lvl_idx(t_side_ff, cnt_ff[PRICE_W-1:0]);
            cnt_in     = t_side_ff ? cnt_ff + 1'b1 : cnt_ff - 1'b1;
            chk_idx_in = cnt_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff && lvl_q.occupied) begin
               state_in = S_STAT;
               if (!t_side_ff) begin
                  bid_valid_in = 1'b1;
                  best_bid_in  = chk_idx_ff[PRICE_W-1:0];
               end else begin
                  offer_valid_in = 1'b1;
                  best_offer_in  = chk_idx_ff[PRICE_W-1:0];
               end
            end else if (chk_vld_ff && !t_side_ff && (chk_idx_ff[PRICE_W-1:0] == '0)) begin
               state_in     = S_STAT;
               bid_valid_in = 1'b0;
               best_bid_in  = '0;
            end else if (chk_vld_ff && t_side_ff
                         && (chk_idx_ff[PRICE_W-1:0] == PRICE_W'(PRICE_TICKS - 1))) begin
               state_in       = S_STAT;
               offer_valid_in = 1'b0;
               best_offer_in  = '0;
            end
         end
         S_STAT: begin
            if (touched_ff) begin
               if (!t_side_ff) begin
                  if ((old_bv_ff && (old_bid_ff == t_price_ff))
                      || (bid_valid_ff && (best_bid_ff == t_price_ff))) begin
                     status_in = ST_NEW_BID;
                  end
               end else begin
                  if ((old_ov_ff && (old_offer_ff == t_price_ff))
                      || (offer_valid_ff && (best_offer_ff == t_price_ff))) begin
                     status_in = ST_NEW_OFFER;
                  end
               end
            end
            state_in = S_OB1;
         end
         S_OB1: begin
            lvl_raddr = lvl_idx(1'b0, best_bid_ff);
            state_in  = S_OB2;
         end
         S_OB2: begin
            lv_in      = lvl_q;
            slot_raddr = lvl_q.head;
            lvl_raddr  = lvl_idx(1'b1, best_offer_ff);
            state_in   = S_OB3;
         end
         S_OB3: begin
            res_in.bid_present = bid_valid_ff;
            if (bid_valid_ff) begin
               res_in.best_bid_price = 10'(best_bid_ff);
               res_in.best_bid_total = lv_ff.total;
               res_in.bid_head_id    = slot_q.ord_id;
               res_in.bid_head_qty   = slot_q.qty;
            end else begin
               res_in.best_bid_price = '0;
               res_in.best_bid_total = '0;
               res_in.bid_head_id    = '0;
               res_in.bid_head_qty   = '0;
            end
            lv_in      = lvl_q;
            slot_raddr = lvl_q.head;
            state_in   = S_OB4;
         end
         S_OB4: begin
            res_in.status        = status_ff;
            res_in.offer_present = offer_valid_ff;
            if (offer_valid_ff) begin
               res_in.best_offer_price = 10'(best_offer_ff);
               res_in.best_offer_total = lv_ff.total;
               res_in.offer_head_id    = slot_q.ord_id;
               res_in.offer_head_qty   = slot_q.qty;
            end else begin
               res_in.best_offer_price = '0;
               res_in.best_offer_total = '0;
               res_in.offer_head_id    = '0;
               res_in.offer_head_qty   = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLR;
         cnt_ff         <= '0;
         chk_vld_ff     <= 1'b0;
         bid_valid_ff   <= 1'b0;
         best_bid_ff    <= '0;
         offer_valid_ff <= 1'b0;
         best_offer_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         chk_vld_ff     <= chk_vld_in;
         bid_valid_ff   <= bid_valid_in;
         best_bid_ff    <= best_bid_in;
         offer_valid_ff <= offer_valid_in;
         best_offer_ff  <= best_offer_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pm_ff        <= pm_in;
      chk_idx_ff   <= chk_idx_in;
      s_ff         <= s_in;
      sd_ff        <= sd_in;
      lv_ff        <= lv_in;
      l_ff         <= l_in;
      t_side_ff    <= t_side_in;
      t_price_ff   <= t_price_in;
      touched_ff   <= touched_in;
      occ_new_ff   <= occ_new_in;
      old_bv_ff    <= old_bv_in;
      old_bid_ff   <= old_bid_in;
      old_ov_ff    <= old_ov_in;
      old_offer_ff <= old_offer_in;
      status_ff    <= status_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   `LOB_ASSERT_NXT(a_done_loads, (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == S_IDLE), "finished response not loaded")
   `LOB_ASSERT_IMP(a_bid_zero, !bid_valid_ff, best_bid_ff == '0, "best bid nonzero with no bid")
   `LOB_ASSERT_IMP(a_offer_zero, !offer_valid_ff, best_offer_ff == '0, "best offer nonzero with no offer")
   `LOB_ASSERT_IMP(a_status_range, rsp_valid_ff, rsp_ff.status <= ST_BAD_QTY, "response status out of range")

endmodule

// ----- verif/lob_checker.sv -----
// order book checker: predicts every book event and compares each response
`timescale 1ns / 1ps

module lob_checker
   import lob_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);

   // shadow copy of the book
   logic              slot_live [ORDER_SLOTS];
   logic [31:0]       slot_oid [ORDER_SLOTS];
   logic              slot_sd [ORDER_SLOTS];
   logic [9:0]        slot_px [ORDER_SLOTS];
   logic [31:0]       slot_q [ORDER_SLOTS];
   logic [LINK_W-1:0] slot_up [ORDER_SLOTS];
   logic [LINK_W-1:0] slot_dn [ORDER_SLOTS];
   logic              lvl_busy [LVL_DEPTH];
   logic [LINK_W-1:0] lvl_first [LVL_DEPTH];
   logic [LINK_W-1:0] lvl_last [LVL_DEPTH];
   logic [47:0]       lvl_sum [LVL_DEPTH];
   logic              bid_ok, offer_ok;
   logic [9:0]        bid_px, offer_px;

   rsp_type expected_rsp [$];

   initial errors = 0;
   initial pending = 0;

   function automatic int level_of(logic sd, logic [9:0] px);
      return sd ? PRICE_TICKS + int'(px) : int'(px);
   endfunction

   function automatic logic [47:0] sum_up(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + 49'(b);
      return s[48] ? TOTAL_MAX : s[47:0];
   endfunction

   function automatic logic [47:0] sum_down(logic [47:0] a, logic [31:0] b);
      return (48'(b) > a) ? 48'd0 : a - 48'(b);
   endfunction

   task automatic unlink_slot(int s);
      int lv;
      int p;
      int n;
      lv = level_of(slot_sd[s], slot_px[s]);
      p = int'(slot_up[s]);
      n = int'(slot_dn[s]);
      if (p < ORDER_SLOTS) slot_dn[p] = slot_dn[s]; else lvl_first[lv] = slot_dn[s];
      if (n < ORDER_SLOTS) slot_up[n] = slot_up[s]; else lvl_last[lv] = slot_up[s];
      lvl_sum[lv] = sum_down(lvl_sum[lv], slot_q[s]);
      if (int'(lvl_first[lv]) >= ORDER_SLOTS) begin
         lvl_busy[lv] = 1'b0;
         lvl_sum[lv] = '0;
      end
      slot_live[s] = 1'b0;
   endtask

   task automatic book_event(input req_type r, output rsp_type e);
      int s;
      int lv;
      int p;
      int h;
      logic [31:0] q;
      logic [31:0] old;
      logic [2:0] st;
      logic hit;
      logic tsd;
      logic [9:0] tpx;
      logic obv, oov;
      logic [9:0] obp, oop;
      st = ST_NONE;
      hit = 1'b0;
      tsd = 1'b0;
      tpx = '0;
      obv = bid_ok;
      oov = offer_ok;
      obp = bid_px;
      oop = offer_px;
      q = r.quantity;
      if (r.func == FN_ADD) begin
         if (q == 0) begin
            st = ST_BAD_QTY;
         end else begin
            s = 0;
            while (s < ORDER_SLOTS && slot_live[s]) s++;
            if (s >= ORDER_SLOTS) begin
               st = ST_FULL;
            end else begin
               lv = level_of(r.side, r.price);
               slot_live[s] = 1'b1;
               slot_oid[s] = r.ord_id;
               slot_sd[s] = r.side;
               slot_px[s] = r.price;
               slot_q[s] = q;
               slot_dn[s] = LINK_NULL;
               if (lvl_busy[lv] && int'(lvl_last[lv]) < ORDER_SLOTS) begin
                  slot_up[s] = lvl_last[lv];
                  slot_dn[int'(lvl_last[lv])] = LINK_W'(s);
                  lvl_last[lv] = LINK_W'(s);
                  lvl_sum[lv] = sum_up(lvl_sum[lv], q);
               end else begin
                  slot_up[s] = LINK_NULL;
                  lvl_busy[lv] = 1'b1;
                  lvl_first[lv] = LINK_W'(s);
                  lvl_last[lv] = LINK_W'(s);
                  lvl_sum[lv] = 48'(q);
               end
               hit = 1'b1;
               tsd = r.side;
               tpx = r.price;
            end
         end
      end else begin
         s = 0;
         while (s < ORDER_SLOTS && !(slot_live[s] && slot_oid[s] == r.ord_id)) s++;
         if (s >= ORDER_SLOTS) begin
            st = ST_UNKNOWN;
         end else if (r.func == FN_TRADE && q > slot_q[s]) begin
            st = ST_BAD_QTY;
         end else begin
            old = slot_q[s];
            hit = 1'b1;
            tsd = slot_sd[s];
            tpx = slot_px[s];
            lv = level_of(tsd, tpx);
            if (r.func == FN_CANCEL || (r.func == FN_TRADE && q == old) ||
                (r.func == FN_CHANGE && q == 0)) begin
               unlink_slot(s);
            end else if (r.func == FN_TRADE) begin
               slot_q[s] = old - q;
               lvl_sum[lv] = sum_down(lvl_sum[lv], q);
            end else begin
               if (q < old) lvl_sum[lv] = sum_down(lvl_sum[lv], old - q);
               else lvl_sum[lv] = sum_up(lvl_sum[lv], q - old);
               slot_q[s] = q;
            end
         end
      end
      // rescan both sides for the best level
      bid_ok = 1'b0;
      bid_px = '0;
      for (p = PRICE_TICKS - 1; p >= 0; p--) begin
         if (lvl_busy[p]) begin
            bid_ok = 1'b1;
            bid_px = 10'(p);
            break;
         end
      end
      offer_ok = 1'b0;
      offer_px = '0;
      for (p = 0; p < PRICE_TICKS; p++) begin
         if (lvl_busy[PRICE_TICKS + p]) begin
            offer_ok = 1'b1;
            offer_px = 10'(p);
            break;
         end
      end
      if (hit) begin
         if (!tsd) begin
            if ((obv && obp == tpx) || (bid_ok && bid_px == tpx)) st = ST_NEW_BID;
         end else begin
            if ((oov && oop == tpx) || (offer_ok && offer_px == tpx)) st = ST_NEW_OFFER;
         end
      end
      e = '0;
      e.status = st;
      if (bid_ok) begin
         lv = level_of(1'b0, bid_px);
         h = int'(lvl_first[lv]);
         e.bid_present = 1'b1;
         e.best_bid_price = bid_px;
         e.best_bid_total = lvl_sum[lv];
         if (h < ORDER_SLOTS) begin
            e.bid_head_id = slot_oid[h];
            e.bid_head_qty = slot_q[h];
         end
      end
      if (offer_ok) begin
         lv = level_of(1'b1, offer_px);
         h = int'(lvl_first[lv]);
         e.offer_present = 1'b1;
         e.best_offer_price = offer_px;
         e.best_offer_total = lvl_sum[lv];
         if (h < ORDER_SLOTS) begin
            e.offer_head_id = slot_oid[h];
            e.offer_head_qty = slot_q[h];
         end
      end
   endtask

   task automatic check_field(string nm, logic [63:0] x, logic [63:0] a);
      if (x !== a) begin
         $error("%s: expected %0h, got %0h", nm, x, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < ORDER_SLOTS; i++) slot_live[i] = 1'b0;
         for (int i = 0; i < LVL_DEPTH; i++) lvl_busy[i] = 1'b0;
         bid_ok = 1'b0;
         offer_ok = 1'b0;
         bid_px = '0;
         offer_px = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response transaction with nothing expected");
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("status", e.status, rsp_data.status);
               check_field("bid_present", e.bid_present, rsp_data.bid_present);
               check_field("best_bid_price", e.best_bid_price, rsp_data.best_bid_price);
               check_field("best_bid_total", e.best_bid_total, rsp_data.best_bid_total);
               check_field("bid_head_id", e.bid_head_id, rsp_data.bid_head_id);
               check_field("bid_head_qty", e.bid_head_qty, rsp_data.bid_head_qty);
               check_field("offer_present", e.offer_present, rsp_data.offer_present);
               check_field("best_offer_price", e.best_offer_price,
                           rsp_data.best_offer_price);
               check_field("best_offer_total", e.best_offer_total,
                           rsp_data.best_offer_total);
               check_field("offer_head_id", e.offer_head_id, rsp_data.offer_head_id);
               check_field("offer_head_qty", e.offer_head_qty, rsp_data.offer_head_qty);
            end
         end
         if (req_valid && req_ready) begin
            book_event(req_data, e);
            expected_rsp.push_back(e);
         end
      end
      pending <= expected_rsp.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// order book testbench top: clock, reset, event stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import lob_pkg::*;

   localparam int LIMIT = 20_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      errors;
   int      pending;
   int      cycles = 0;

   int          live_id [$];
   logic [31:0] live_qty [$];
   int          burst_left = 4;
   int          rdy_mode = 0;
   int          rdy_span = 0;
   int          id_ctr = 256;

   limit_order_book u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   lob_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .errors(errors), .pending(pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // receiver stall pattern: free running, random, or mostly stalled
   always @(posedge clock) begin
      if (rdy_span == 0) begin
         rdy_mode <= $urandom_range(0, 2);
         rdy_span <= $urandom_range(50, 400);
      end else begin
         rdy_span <= rdy_span - 1;
      end
      case (rdy_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   function automatic req_type mk(logic [1:0] f, logic [31:0] id, logic sd,
                                  logic [9:0] px, logic [31:0] q);
      req_type r;
      r.func = f;
      r.ord_id = id;
      r.side = sd;
      r.price = px;
      r.quantity = q;
      return r;
   endfunction

   function automatic int find_live(logic [31:0] id);
      foreach (live_id[i]) if (live_id[i] == int'(id)) return i;
      return -1;
   endfunction

   // rough tracking of resting orders so random events target live ones
   task automatic note_event(req_type r);
      int k;
      k = find_live(r.ord_id);
      case (r.func)
         FN_ADD: begin
            if (r.quantity != 0) begin
               live_id.push_back(int'(r.ord_id));
               live_qty.push_back(r.quantity);
            end
         end
         FN_CANCEL: begin
            if (k >= 0) begin
               live_id.delete(k);
               live_qty.delete(k);
            end
         end
         FN_TRADE: begin
            if (k >= 0 && r.quantity <= live_qty[k]) begin
               if (r.quantity == live_qty[k]) begin
                  live_id.delete(k);
                  live_qty.delete(k);
               end else begin
                  live_qty[k] = live_qty[k] - r.quantity;
               end
            end
         end
         default: begin
            if (k >= 0) begin
               if (r.quantity == 0) begin
                  live_id.delete(k);
                  live_qty.delete(k);
               end else begin
                  live_qty[k] = r.quantity;
               end
            end
         end
      endcase
   endtask

   task automatic send(req_type r);
      note_event(r);
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
   endtask

   task automatic random_event();
      int roll;
      int k;
      logic [31:0] id;
      logic [31:0] q;
      logic [9:0] px;
      logic [1:0] f;
      roll = $urandom_range(0, 99);
      px = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(500, 530)) : 10'($urandom);
      if (roll < 3) begin
         // id that rests nowhere
         id = $urandom;
         while (find_live(id) >= 0) id = $urandom;
         f = 2'($urandom_range(1, 3));
         send(mk(f, id, 1'($urandom), px, $urandom));
      end else if (roll < 6) begin
         send(mk(FN_ADD, $urandom, 1'($urandom), px, 32'd0));
      end else if (live_id.size() < 4 || (live_id.size() < 50 && roll < 45)) begin
         id = {16'($urandom), 16'(id_ctr)};
         id_ctr++;
         q = ($urandom_range(0, 1) == 1) ? $urandom : 32'($urandom_range(1, 1000));
         send(mk(FN_ADD, id, 1'($urandom), px, q));
      end else begin
         k = $urandom_range(0, live_id.size() - 1);
         id = 32'(live_id[k]);
         f = (live_id.size() > 50) ? FN_CANCEL : 2'($urandom_range(1, 3));
         case (f)
            FN_TRADE: begin
               roll = $urandom_range(0, 9);
               if (roll == 0 && live_qty[k] != 32'hFFFF_FFFF) q = live_qty[k] + 1;
               else if (roll < 4) q = live_qty[k];
               else q = $urandom_range(0, live_qty[k]);
            end
            FN_CHANGE: begin
               roll = $urandom_range(0, 5);
               if (roll == 0) q = 0;
               else if (roll < 3) q = $urandom;
               else q = $urandom_range(1, 2000);
            end
            default: begin
               q = $urandom;
            end
         endcase
         send(mk(f, id, 1'($urandom), 10'($urandom), q));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every function, the zero-quantity, oversize-trade and unknown-id error paths
      send(mk(FN_ADD, 32'hFFFF_FFFF, 1'b0, 10'd1023, 32'hFFFF_FFFF));
      send(mk(FN_ADD, 32'h0, 1'b1, 10'd0, 32'd1));
      send(mk(FN_ADD, 32'h5, 1'b0, 10'd200, 32'd0));
      send(mk(FN_ADD, 32'h10, 1'b0, 10'd0, 32'd7));
      send(mk(FN_ADD, 32'h11, 1'b1, 10'd1023, 32'd9));
      send(mk(FN_ADD, 32'h20, 1'b0, 10'd1023, 32'd50));
      send(mk(FN_ADD, 32'h20, 1'b0, 10'd1023, 32'd60));
      send(mk(FN_TRADE, 32'h20, 1'b0, 10'd0, 32'd0));
      send(mk(FN_TRADE, 32'h20, 1'b0, 10'd0, 32'd51));
      send(mk(FN_TRADE, 32'h20, 1'b0, 10'd0, 32'd20));
      send(mk(FN_CHANGE, 32'h20, 1'b0, 10'd0, 32'd100));
      send(mk(FN_CHANGE, 32'h20, 1'b0, 10'd0, 32'd3));
      send(mk(FN_TRADE, 32'h20, 1'b0, 10'd0, 32'd3));
      send(mk(FN_CHANGE, 32'h20, 1'b1, 10'd0, 32'd0));
      send(mk(FN_CANCEL, 32'hFFFF_FFFF, 1'b0, 10'd0, 32'd0));
      send(mk(FN_CANCEL, 32'hFFFF_FFFF, 1'b0, 10'd0, 32'd0));
      send(mk(FN_TRADE, 32'hABCD_0000, 1'b0, 10'd0, 32'd1));
      send(mk(FN_CHANGE, 32'hABCD_0001, 1'b1, 10'd0, 32'd1));
      send(mk(FN_TRADE, 32'h0, 1'b1, 10'd0, 32'd1));
      send(mk(FN_CANCEL, 32'h10, 1'b0, 10'd0, 32'd0));
      send(mk(FN_CHANGE, 32'h11, 1'b1, 10'd0, 32'hFFFF_FFFF));
      send(mk(FN_CANCEL, 32'h11, 1'b1, 10'd0, 32'd0));
      // hold off until the book has answered everything
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (950) random_event();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
